/* hw/rtl/sorted_insertion_priority_queue_core_defines.svh */
// Assertion macros for the sorted insertion priority queue.
// Taken in by the top level only; depends on nothing else.
`ifndef SORTED_INSERTION_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_INSERTION_PRIORITY_QUEUE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/spq_pkg.sv */
// Shared types and constants for the sorted insertion priority queue.
// Used by spq_cell and the top level; depends on nothing.
package spq_pkg;

   localparam int DATA_W        = 32;
   localparam int DEPTH_DEFAULT = 8;
   localparam int CNT_OUT_W     = 4;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      op_type                   op;
      logic signed [DATA_W-1:0] in_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_value;
      status_type               status;
      logic [CNT_OUT_W-1:0]     entry_count;
   } rsp_type;

   // Broadcast from the top level to every cell of the row.
   typedef struct packed {
      logic                     do_insert;
      logic                     do_remove;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

/* hw/rtl/spq_cell.sv */
// One slot of the sorted row: holds a value and takes part in the shift.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic                     occupied,
   input  logic                     left_greater,
   input  logic signed [DATA_W-1:0] left_value,
   input  logic signed [DATA_W-1:0] right_value,
   output logic                     greater,
   output logic signed [DATA_W-1:0] value
);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   // The row is kept in descending order, so the cells that hold a value
   // greater than the new one form an unbroken run starting at cell 0.
   assign greater = occupied && ($signed(value_ff) > $signed(ctrl.value));
   assign value   = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.do_insert) begin
         if (!greater) begin
            // The first cell past the run takes the new value; the rest
            // take their left neighbor's value.
            value_in = left_greater ? ctrl.value : left_value;
         end
      end else if (ctrl.do_remove) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

/* hw/rtl/sorted_insertion_priority_queue_core.sv */
// Bounded priority queue of DEPTH signed 32-bit values. Each request either
// inserts a value or removes the largest stored one, and each request gives
// exactly one response carrying the removed value, a status and the entry
// count after the operation. The block takes one request per clock while no
// held response is stalled, and the response appears in the output
// register on the cycle after acceptance, set by one compare-and-shift pass
// across the row of cells, which each compare their value against the
// broadcast request in parallel. The row holds values in descending order
// with the largest in the first cell, so a remove reads that cell and
// shifts the row down. An insert into a full queue is dropped with status
// full, and a remove from an empty queue returns -1 with status empty.
// No clearing pass is needed: reset clears only the count and rsp_valid.
`include "sorted_insertion_priority_queue_core_defines.svh"

module sorted_insertion_priority_queue_core import spq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;

   logic             accept;
   logic             is_full;
   logic             is_empty;
   cell_ctrl_type    ctrl;

   logic signed [DATA_W-1:0] value_chain   [DEPTH];
   logic                     greater_chain [DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);

   assign ctrl.do_insert = accept && (req_data.op == OP_INSERT) && !is_full;
   assign ctrl.do_remove = accept && (req_data.op == OP_REMOVE) && !is_empty;
   assign ctrl.value     = req_data.in_value;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                     occupied;
      logic                     left_greater;
      logic signed [DATA_W-1:0] left_value;
      logic signed [DATA_W-1:0] right_value;

      assign occupied = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_first
         assign left_greater = 1'b1;
         assign left_value   = req_data.in_value;
      end else begin : g_inner
         assign left_greater = greater_chain[i-1];
         assign left_value   = value_chain[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_value = value_chain[i];
      end else begin : g_body
         assign right_value = value_chain[i+1];
      end

      spq_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .occupied     (occupied),
         .left_greater (left_greater),
         .left_value   (left_value),
         .right_value  (right_value),
         .greater      (greater_chain[i]),
         .value        (value_chain[i])
      );
   end

   always_comb begin
      count_in                = count_ff;
      rsp_data_in.out_value   = '0;
      rsp_data_in.status      = ST_DONE;
      unique case (req_data.op)
         OP_INSERT: begin
            if (is_full) begin
               rsp_data_in.status = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (is_empty) begin
               rsp_data_in.status    = ST_EMPTY;
               rsp_data_in.out_value = '1;
            end else begin
               count_in              = count_ff - CNT_W'(1);
               rsp_data_in.out_value = value_chain[0];
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      rsp_data_in.entry_count = CNT_OUT_W'(count_in);
      rsp_valid_in            = accept || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SPQ_ASSERT_NEXT(a_remove_count, clock, reset, ctrl.do_remove,
      count_ff == $past(count_ff) - CNT_W'(1),
      "count did not drop after a remove")
   `SPQ_ASSERT_NEXT(a_insert_count, clock, reset, ctrl.do_insert,
      count_ff == $past(count_ff) + CNT_W'(1),
      "count did not rise after an insert")
   `SPQ_ASSERT_SAME(a_empty_resp, clock, reset,
      rsp_valid_ff && (rsp_data_ff.status == ST_EMPTY),
      (rsp_data_ff.out_value == '1) && (rsp_data_ff.entry_count == '0),
      "empty remove response is malformed")

endmodule

/* sim/tb.sv */
// Self-checking bench for sorted_insertion_priority_queue_core: a shadow queue predicts
// every response, and random request gaps and response stalls stress the handshakes.
// Depends only on spq_pkg and the core itself.
`timescale 1ns / 1ps

module tb;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
   localparam int RUN_LIMIT_NS = 1_000_000;

   // Keeps its own sorted copy of the queue and the responses still owed.
   class shadow_pq;
      logic signed [DATA_W-1:0] held_vals [QUEUE_DEPTH];
      int unsigned held_count;
      rsp_type awaited_rsps [$];
      int failures, checked, n_insert, n_remove, n_full, n_empty;

      function new();
         held_count = 0;
         failures = 0;
         checked = 0;
         n_insert = 0;
         n_remove = 0;
         n_full = 0;
         n_empty = 0;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int pos;
         e.out_value = '0;
         e.status = ST_DONE;
         if (r.op == OP_INSERT) begin
            n_insert++;
            if (held_count >= QUEUE_DEPTH) begin
               e.status = ST_FULL;
               n_full++;
            end else begin
               // Equal values stay behind earlier arrivals.
               pos = held_count;
               while (pos > 0 && $signed(held_vals[pos-1]) > $signed(r.in_value)) begin
                  held_vals[pos] = held_vals[pos-1];
                  pos--;
               end
               held_vals[pos] = r.in_value;
               held_count++;
            end
         end else begin
            n_remove++;
            if (held_count == 0) begin
               e.status = ST_EMPTY;
               e.out_value = -32'sd1;
               n_empty++;
            end else begin
               held_count--;
               e.out_value = held_vals[held_count];
            end
         end
         e.entry_count = CNT_OUT_W'(held_count);
         awaited_rsps.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (awaited_rsps.size() == 0) begin
            $error("response with no request outstanding: out_value %0d", got.out_value);
            failures++;
            return;
         end
         e = awaited_rsps.pop_front();
         checked++;
         if (got.out_value !== e.out_value) begin
            $error("out_value: expected %0d, actual %0d", e.out_value, got.out_value);
            failures++;
         end
         if (got.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, got.status);
            failures++;
         end
         if (got.entry_count !== e.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", e.entry_count, got.entry_count);
            failures++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   logic gaps_on;
   logic stalls_on;
   int   long_hold_req;

   shadow_pq tracker = new();

   sorted_insertion_priority_queue_core #(
      .DEPTH(QUEUE_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("sorted_insertion_priority_queue_core regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_response(rsp_data);
   end

   // Response side: short random stalls, or one long hold-off on request.
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req > 0) begin
            stall_left = long_hold_req;
            long_hold_req = 0;
         end else if (stall_left == 0 && stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 5);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return -32'sd1;
         4, 5: return $signed(32'($urandom_range(0, 15))) - 32'sd8;
         default: return $signed($urandom);
      endcase
   endfunction

   task automatic send_request(input op_type op, input logic signed [DATA_W-1:0] value);
      req_type r;
      r.op = op;
      r.in_value = value;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      tracker.note_request(r);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 4)) @(negedge clock);
      end
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.awaited_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_block(input int n_items, input int insert_pct);
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 99) < insert_pct)
            send_request(OP_INSERT, pick_value());
         else
            send_request(OP_REMOVE, $signed($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      long_hold_req = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty remove, fill with extremes and duplicates, overflow, drain.
      send_request(OP_REMOVE, 32'sh7FFF_FFFF);
      send_request(OP_INSERT, 32'sh7FFF_FFFF);
      send_request(OP_INSERT, 32'sh8000_0000);
      send_request(OP_INSERT, -32'sd1);
      send_request(OP_INSERT, 32'sd0);
      send_request(OP_INSERT, 32'sd1);
      send_request(OP_INSERT, 32'sd5);
      send_request(OP_INSERT, 32'sd5);
      send_request(OP_INSERT, -32'sd5);
      send_request(OP_INSERT, 32'sd42);
      send_request(OP_INSERT, 32'sh8000_0000);
      for (int i = 0; i < QUEUE_DEPTH; i++)
         send_request(OP_REMOVE, $signed($urandom));
      send_request(OP_REMOVE, 32'sh8000_0000);

      // Random walk over the fill level, with the insert share changing per block.
      for (int blk = 0; blk < 5; blk++)
         send_random_block(40, (blk % 3 == 0) ? 75 : (blk % 3 == 1) ? 25 : 50);

      // The receiver holds off while requests keep coming, so the core backs up.
      long_hold_req = 48;
      send_random_block(24, 60);

      for (int blk = 0; blk < 5; blk++)
         send_random_block(40, (blk % 2 == 0) ? 70 : 30);

      wait_for_drain();

      send_random_block(80, 50);

      // Closing stretch at full rate on both sides.
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      for (int blk = 0; blk < 4; blk++)
         send_random_block(25, (blk % 2 == 0) ? 80 : 20);

      wait_for_drain();
      repeat (4) @(posedge clock);

      $display("covered %0d inserts (%0d dropped on full) and %0d removes (%0d on empty)",
               tracker.n_insert, tracker.n_full, tracker.n_remove, tracker.n_empty);
      $display("%0d responses checked, %0d mismatches", tracker.checked, tracker.failures);
      if (tracker.failures == 0 && tracker.awaited_rsps.size() == 0)
         $display("sorted_insertion_priority_queue_core regression: pass");
      else
         $display("sorted_insertion_priority_queue_core regression: fail");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_insertion_priority_queue_core.sv
sim/tb.sv
